// ===== design/dfsmc_pkg.sv =====
// Shared constants, payload types and grid port types for the maze carver.
// No dependencies; used by dfsmc_grid and dfs_maze_carver.
`timescale 1ns / 1ps

package dfsmc_pkg;

    localparam int MAX_SIDE    = 128;
    localparam int STACK_DEPTH = 4096;
    localparam int COORD_W     = 7;
    localparam int ROW_AW      = $clog2(MAX_SIDE);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STK_AW + 1;
    localparam int START_POS   = 1;

    localparam logic [COORD_W-1:0] SIDE_AT_RESET = 7'd67;

    typedef enum logic [1:0] {
        DIR_COL_INC,
        DIR_COL_DEC,
        DIR_ROW_INC,
        DIR_ROW_DEC
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_RD_UP,
        ST_RD_MID,
        ST_RD_DN,
        ST_DECIDE,
        ST_WR_WALL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] choice;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic               carved;
        logic [COORD_W-1:0] wall_row;
        logic [COORD_W-1:0] wall_col;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               popped;
        logic               finished;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] row;
    } grid_rd_t;

    typedef struct packed {
        logic                clear;
        logic                en;
        logic [ROW_AW-1:0]   row;
        logic [MAX_SIDE-1:0] data;
    } grid_wr_t;

endpackage

// ===== design/dfs_maze_carver.sv =====
// Top level of the depth-first maze carver: control sequencer, coordinate stack,
// config register and result register. Depends on dfsmc_pkg and dfsmc_grid.
`timescale 1ns / 1ps
//
//  channel  signals                              beat
//  -------  -----------------------------------  --------------------------------
//  in       in_valid / in_ready / in_data        one carving step (choice, restart)
//  out      out_valid / out_ready / out_data     one step result
//  cfg      cfg_valid / cfg_ready / cfg_data     maze_side write, always ready
//
//  A step that pops or carves reads the stack top, then three grid rows through the
//  single read port of the row-wide grid memory, plus the wall row of a column carve;
//  a restart or an empty stack goes straight to the result register.
//  Reset and restart mark all grid rows unwritten at once; no clearing pass.
//  The result register holds while out_ready is low; the next beat is taken meanwhile.

module dfs_maze_carver (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  dfsmc_pkg::in_item_t      in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output dfsmc_pkg::out_item_t     out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [dfsmc_pkg::COORD_W-1:0] cfg_data
);

    localparam int CW = dfsmc_pkg::COORD_W;
    localparam int MS = dfsmc_pkg::MAX_SIDE;
    localparam int RA = dfsmc_pkg::ROW_AW;
    localparam logic [MS-1:0] ROW_ONE = {{(MS-1){1'b0}}, 1'b1};

    function automatic logic in_bounds(input logic [8:0] v, input logic [7:0] side);
        in_bounds = (v >= 9'd1) && (({1'b0, v} + 10'd1) < {2'b0, side})
                    && (v < 9'(MS));
    endfunction

    function automatic logic [1:0] mod3(input logic [7:0] x);
        logic [3:0] s;
        s = {2'b0, x[1:0]} + {2'b0, x[3:2]} + {2'b0, x[5:4]} + {2'b0, x[7:6]};
        if (s >= 4'd12)
        begin
            mod3 = 2'd0;
        end
        else if (s >= 4'd9)
        begin
            mod3 = 2'(s - 4'd9);
        end
        else if (s >= 4'd6)
        begin
            mod3 = 2'(s - 4'd6);
        end
        else if (s >= 4'd3)
        begin
            mod3 = 2'(s - 4'd3);
        end
        else
        begin
            mod3 = s[1:0];
        end
    endfunction

    dfsmc_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                  maze_side_reg, maze_side_next;
    logic [dfsmc_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                           seed_reg, seed_next;
    logic [7:0]                     choice_reg, choice_next;
    logic [CW-1:0]                  r_reg, r_next;
    logic [CW-1:0]                  c_reg, c_next;
    logic [MS-1:0]                  up_reg, up_next;
    logic [MS-1:0]                  mid_reg, mid_next;
    logic [MS-1:0]                  dn_reg, dn_next;
    dfsmc_pkg::out_item_t           res_reg, res_next;
    dfsmc_pkg::out_item_t           out_data_reg, out_data_next;
    logic                           out_valid_reg, out_valid_next;

    logic [2*CW-1:0]                stk_mem [dfsmc_pkg::STACK_DEPTH];
    logic [2*CW-1:0]                stk_q;
    logic [2*CW-1:0]                stk_top;
    logic                           stk_rd_en;
    logic [dfsmc_pkg::STK_AW-1:0]   stk_rd_addr;
    logic                           stk_wr_en;
    logic [dfsmc_pkg::STK_AW-1:0]   stk_wr_addr;
    logic [2*CW-1:0]                stk_wr_data;

    dfsmc_pkg::grid_rd_t            grid_rd;
    dfsmc_pkg::grid_wr_t            grid_wr;
    logic [MS-1:0]                  grid_q;

    logic                           accept;
    logic                           out_load;
    logic [7:0]                     side_eff;
    logic [8:0]                     r9, c9;
    logic [8:0]                     nb_r [4];
    logic [8:0]                     nb_c [4];
    logic [3:0]                     wall_bit;
    logic [3:0]                     cand;
    logic [2:0]                     n_cand;
    logic [1:0]                     pick;
    logic [1:0]                     seen;
    dfsmc_pkg::dir_t                k;
    logic                           vertical;
    logic [CW-1:0]                  wr_row, wr_col, cl_row, cl_col;
    logic [CW-1:0]                  stk_row, stk_col;

    dfsmc_grid u_grid (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (grid_rd),
        .rd_data (grid_q),
        .wr      (grid_wr)
    );

    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en)
        begin
            stk_q <= stk_mem[stk_rd_addr];
        end
    end

    assign in_ready  = (state_reg == dfsmc_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = (state_reg == dfsmc_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign side_eff  = ({1'b0, maze_side_reg} > 8'(MS)) ? 8'(MS) : {1'b0, maze_side_reg};
    // start cell stands in for stack entry 0 from reset on, until a restart writes it
    assign stk_top   = (seed_reg && (count_reg == dfsmc_pkg::CNT_W'(1)))
                       ? {CW'(dfsmc_pkg::START_POS), CW'(dfsmc_pkg::START_POS)} : stk_q;
    assign stk_row   = stk_top[2*CW-1:CW];
    assign stk_col   = stk_top[CW-1:0];

    // neighbour candidates of the current top cell
    always_comb
    begin
        r9 = {2'b0, r_reg};
        c9 = {2'b0, c_reg};
        nb_r[0] = r9;
        nb_c[0] = c9 + 9'd2;
        nb_r[1] = r9;
        nb_c[1] = c9 - 9'd2;
        nb_r[2] = r9 + 9'd2;
        nb_c[2] = c9;
        nb_r[3] = r9 - 9'd2;
        nb_c[3] = c9;
        wall_bit[0] = mid_reg[nb_c[0][RA-1:0]];
        wall_bit[1] = mid_reg[nb_c[1][RA-1:0]];
        wall_bit[2] = dn_reg[c_reg[RA-1:0]];
        wall_bit[3] = up_reg[c_reg[RA-1:0]];
        for (int i = 0; i < 4; i++)
        begin
            cand[i] = in_bounds(nb_r[i], side_eff) && in_bounds(nb_c[i], side_eff)
                      && wall_bit[i];
        end
        n_cand = {2'b0, cand[0]} + {2'b0, cand[1]} + {2'b0, cand[2]} + {2'b0, cand[3]};
        case (n_cand)
            3'd2:    pick = {1'b0, choice_reg[0]};
            3'd3:    pick = mod3(choice_reg);
            3'd4:    pick = choice_reg[1:0];
            default: pick = 2'd0;
        endcase
        k    = dfsmc_pkg::DIR_COL_INC;
        seen = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand[i])
            begin
                if (seen == pick)
                begin
                    k = dfsmc_pkg::dir_t'(2'(i));
                end
                seen = seen + 2'd1;
            end
        end
        vertical = (k == dfsmc_pkg::DIR_ROW_INC) || (k == dfsmc_pkg::DIR_ROW_DEC);
        case (k)
            dfsmc_pkg::DIR_COL_INC:
            begin
                wr_row = r_reg;
                wr_col = c_reg + 7'd1;
            end
            dfsmc_pkg::DIR_COL_DEC:
            begin
                wr_row = r_reg;
                wr_col = c_reg - 7'd1;
            end
            dfsmc_pkg::DIR_ROW_INC:
            begin
                wr_row = r_reg + 7'd1;
                wr_col = c_reg;
            end
            dfsmc_pkg::DIR_ROW_DEC:
            begin
                wr_row = r_reg - 7'd1;
                wr_col = c_reg;
            end
            default:
            begin
                wr_row = r_reg;
                wr_col = c_reg;
            end
        endcase
        cl_row = nb_r[k][CW-1:0];
        cl_col = nb_c[k][CW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dfsmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.restart || (count_reg == '0))
                    begin
                        state_next = dfsmc_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = dfsmc_pkg::ST_TOP;
                    end
                end
            end
            dfsmc_pkg::ST_TOP:    state_next = dfsmc_pkg::ST_RD_UP;
            dfsmc_pkg::ST_RD_UP:  state_next = dfsmc_pkg::ST_RD_MID;
            dfsmc_pkg::ST_RD_MID: state_next = dfsmc_pkg::ST_RD_DN;
            dfsmc_pkg::ST_RD_DN:  state_next = dfsmc_pkg::ST_DECIDE;
            dfsmc_pkg::ST_DECIDE:
            begin
                if ((n_cand != 3'd0) && vertical)
                begin
                    state_next = dfsmc_pkg::ST_WR_WALL;
                end
                else
                begin
                    state_next = dfsmc_pkg::ST_DONE;
                end
            end
            dfsmc_pkg::ST_WR_WALL: state_next = dfsmc_pkg::ST_DONE;
            dfsmc_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = dfsmc_pkg::ST_IDLE;
                end
            end
            default: state_next = dfsmc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        maze_side_next = maze_side_reg;
        count_next     = count_reg;
        seed_next      = seed_reg;
        choice_next    = choice_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        up_next        = up_reg;
        mid_next       = mid_reg;
        dn_next        = dn_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        stk_rd_en      = 1'b0;
        stk_rd_addr    = '0;
        stk_wr_en      = 1'b0;
        stk_wr_addr    = '0;
        stk_wr_data    = '0;
        grid_rd        = '0;
        grid_wr        = '0;

        if (cfg_valid)
        begin
            maze_side_next = cfg_data;
        end

        if (out_load)
        begin
            out_data_next  = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            dfsmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    choice_next = in_data.choice;
                    res_next    = '0;
                    if (in_data.restart)
                    begin
                        grid_wr.clear = 1'b1;
                        stk_wr_en     = 1'b1;
                        stk_wr_data   = {CW'(dfsmc_pkg::START_POS), CW'(dfsmc_pkg::START_POS)};
                        count_next    = dfsmc_pkg::CNT_W'(1);
                        seed_next     = 1'b0;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.finished = 1'b1;
                    end
                    else
                    begin
                        stk_rd_en   = 1'b1;
                        stk_rd_addr = dfsmc_pkg::STK_AW'(count_reg - 1'b1);
                    end
                end
            end
            dfsmc_pkg::ST_TOP:
            begin
                r_next      = stk_row;
                c_next      = stk_col;
                grid_rd.en  = 1'b1;
                grid_rd.row = RA'(stk_row - 7'd2);
            end
            dfsmc_pkg::ST_RD_UP:
            begin
                up_next     = grid_q;
                grid_rd.en  = 1'b1;
                grid_rd.row = r_reg[RA-1:0];
            end
            dfsmc_pkg::ST_RD_MID:
            begin
                mid_next    = grid_q;
                grid_rd.en  = 1'b1;
                grid_rd.row = RA'(r_reg + 7'd2);
            end
            dfsmc_pkg::ST_RD_DN:
            begin
                dn_next = grid_q;
            end
            dfsmc_pkg::ST_DECIDE:
            begin
                if (n_cand != 3'd0)
                begin
                    res_next.carved   = 1'b1;
                    res_next.wall_row = wr_row;
                    res_next.wall_col = wr_col;
                    res_next.cell_row = cl_row;
                    res_next.cell_col = cl_col;
                    grid_wr.en        = 1'b1;
                    grid_wr.row       = cl_row[RA-1:0];
                    if (vertical)
                    begin
                        // cell row now, wall row after its read returns
                        grid_wr.data = ((k == dfsmc_pkg::DIR_ROW_INC) ? dn_reg : up_reg)
                                       & ~(ROW_ONE << c_reg[RA-1:0]);
                        grid_rd.en   = 1'b1;
                        grid_rd.row  = wr_row[RA-1:0];
                    end
                    else
                    begin
                        grid_wr.data = mid_reg & ~(ROW_ONE << wr_col[RA-1:0])
                                       & ~(ROW_ONE << cl_col[RA-1:0]);
                    end
                    if (count_reg < dfsmc_pkg::CNT_W'(dfsmc_pkg::STACK_DEPTH))
                    begin
                        stk_wr_en   = 1'b1;
                        stk_wr_addr = count_reg[dfsmc_pkg::STK_AW-1:0];
                        stk_wr_data = {cl_row, cl_col};
                        count_next  = count_reg + 1'b1;
                    end
                end
                else
                begin
                    res_next.popped   = 1'b1;
                    res_next.finished = (count_reg == dfsmc_pkg::CNT_W'(1));
                    count_next        = count_reg - 1'b1;
                end
            end
            dfsmc_pkg::ST_WR_WALL:
            begin
                grid_wr.en   = 1'b1;
                grid_wr.row  = res_reg.wall_row[RA-1:0];
                grid_wr.data = grid_q & ~(ROW_ONE << res_reg.wall_col[RA-1:0]);
            end
            dfsmc_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dfsmc_pkg::ST_IDLE;
            maze_side_reg <= dfsmc_pkg::SIDE_AT_RESET;
            count_reg     <= dfsmc_pkg::CNT_W'(1);
            seed_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            maze_side_reg <= maze_side_next;
            count_reg     <= count_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        choice_reg   <= choice_next;
        r_reg        <= r_next;
        c_reg        <= c_next;
        up_reg       <= up_next;
        mid_reg      <= mid_next;
        dn_reg       <= dn_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== design/dfsmc_grid.sv =====
// Wall grid store: one row of wall bits per memory word, one read and one write a cycle.
// Rows never written since reset or restart read as walls, with the start cell open.
// Depends on dfsmc_pkg.
`timescale 1ns / 1ps

module dfsmc_grid (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dfsmc_pkg::grid_rd_t           rd,
    output logic [dfsmc_pkg::MAX_SIDE-1:0] rd_data,
    input  dfsmc_pkg::grid_wr_t           wr
);

    localparam logic [dfsmc_pkg::MAX_SIDE-1:0] ROW_ONE =
        {{(dfsmc_pkg::MAX_SIDE-1){1'b0}}, 1'b1};
    localparam logic [dfsmc_pkg::MAX_SIDE-1:0] START_ROW_INIT =
        ~(ROW_ONE << dfsmc_pkg::START_POS);

    logic [dfsmc_pkg::MAX_SIDE-1:0] mem [dfsmc_pkg::MAX_SIDE];
    logic [dfsmc_pkg::MAX_SIDE-1:0] mem_q;
    logic [dfsmc_pkg::MAX_SIDE-1:0] row_valid_reg;
    logic [dfsmc_pkg::MAX_SIDE-1:0] row_valid_next;
    logic                           rd_valid_reg;
    logic                           rd_valid_next;
    logic [dfsmc_pkg::ROW_AW-1:0]   rd_row_reg;
    logic [dfsmc_pkg::ROW_AW-1:0]   rd_row_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row] <= wr.data;
        end
        if (rd.en)
        begin
            mem_q <= mem[rd.row];
        end
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (wr.clear)
        begin
            row_valid_next = '0;
        end
        else if (wr.en)
        begin
            row_valid_next[wr.row] = 1'b1;
        end
        rd_valid_next = rd_valid_reg;
        rd_row_next   = rd_row_reg;
        if (rd.en)
        begin
            rd_valid_next = row_valid_reg[rd.row];
            rd_row_next   = rd.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rd_row_reg    <= '0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
            rd_row_reg    <= rd_row_next;
        end
    end

    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_data = mem_q;
        end
        else if (rd_row_reg == dfsmc_pkg::ROW_AW'(dfsmc_pkg::START_POS))
        begin
            rd_data = START_ROW_INIT;
        end
        else
        begin
            rd_data = '1;
        end
    end

endmodule
